@@ rtl/core/tcc_pkg.sv @@
// Shared widths, status codes and side-band structs for the triangle circumcircle block.
// No dependencies; tcc_front, the top level and the checker refer to it by scoped names.
`default_nettype none
package tcc_pkg;

  localparam int CoordW = 16;           // vertex coordinate
  localparam int DiffW  = 17;           // vertex difference
  localparam int ProdW  = 34;           // 17 x 17 product
  localparam int DetW   = 36;           // signed determinant D
  localparam int SqW    = 34;           // unsigned squared edge length
  localparam int NumerW = 52;           // signed circumcentre numerator
  localparam int NumW   = 60;           // |numerator| * 256
  localparam int DenW   = 36;           // |D|
  localparam int OutW   = 40;           // centre / radius width
  localparam int RootW  = 41;           // square root bits
  localparam int RadW   = 2 * RootW;    // radicand bits

  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_COLL = 2'd1;
  localparam status_t ST_SAT  = 2'd2;

  // travels alongside the x-centre division
  typedef struct packed {
    logic                     coll;
    logic                     neg;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
  } xside_t;

  // travels alongside the square root
  typedef struct packed {
    logic            coll;
    logic            sat;
    logic [OutW-1:0] px;
    logic [OutW-1:0] py;
  } rside_t;

  typedef struct packed {
    status_t         status;
    logic [OutW-1:0] radius;
    logic [OutW-1:0] center_y;
    logic [OutW-1:0] center_x;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/tcc_front.sv @@
// Front end: edge vectors, determinant D and the circumcentre numerators, six stages.
// Depends on tcc_pkg.
`default_nettype none
module tcc_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              ce,
  input  wire logic                              in_valid,
  input  wire logic signed [tcc_pkg::CoordW-1:0] a_x,
  input  wire logic signed [tcc_pkg::CoordW-1:0] a_y,
  input  wire logic signed [tcc_pkg::CoordW-1:0] b_x,
  input  wire logic signed [tcc_pkg::CoordW-1:0] b_y,
  input  wire logic signed [tcc_pkg::CoordW-1:0] c_x,
  input  wire logic signed [tcc_pkg::CoordW-1:0] c_y,
  output logic                                   out_valid,
  output tcc_pkg::xside_t                        x_side,
  output logic                                   neg_y,
  output logic             [tcc_pkg::NumW-1:0]   num_x,
  output logic             [tcc_pkg::NumW-1:0]   num_y,
  output logic             [tcc_pkg::DenW-1:0]   den
);

  logic [5:0] vld;

  logic signed [tcc_pkg::CoordW-1:0] ax1, ay1, ax2, ay2, ax3, ay3, ax4, ay4, ax5, ay5;
  logic signed [tcc_pkg::DiffW-1:0]  bx1, by1, cx1, cy1, bx2, by2, cx2, cy2, bx3, by3, cx3, cy3;
  logic signed [tcc_pkg::ProdW-1:0]  p1, p2, sbx, sby, scx, scy;
  logic signed [tcc_pkg::DetW-1:0]   det3, det4, det5;
  logic        [tcc_pkg::SqW-1:0]    b2, c2;
  logic signed [tcc_pkg::NumerW-1:0] m1, m2, m3, m4, nx, ny;
  logic        [tcc_pkg::NumerW-1:0] nx_mag, ny_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      // edge vectors relative to vertex a
      ax1 <= a_x;
      ay1 <= a_y;
      bx1 <= tcc_pkg::DiffW'(b_x) - tcc_pkg::DiffW'(a_x);
      by1 <= tcc_pkg::DiffW'(b_y) - tcc_pkg::DiffW'(a_y);
      cx1 <= tcc_pkg::DiffW'(c_x) - tcc_pkg::DiffW'(a_x);
      cy1 <= tcc_pkg::DiffW'(c_y) - tcc_pkg::DiffW'(a_y);
      // cross products and squares
      ax2 <= ax1; ay2 <= ay1;
      bx2 <= bx1; by2 <= by1; cx2 <= cx1; cy2 <= cy1;
      p1  <= bx1 * cy1;
      p2  <= by1 * cx1;
      sbx <= bx1 * bx1;
      sby <= by1 * by1;
      scx <= cx1 * cx1;
      scy <= cy1 * cy1;
      // D and squared lengths
      ax3  <= ax2; ay3 <= ay2;
      bx3  <= bx2; by3 <= by2; cx3 <= cx2; cy3 <= cy2;
      det3 <= (tcc_pkg::DetW'(p1) - tcc_pkg::DetW'(p2)) <<< 1;
      b2   <= tcc_pkg::SqW'(sbx[32:0]) + tcc_pkg::SqW'(sby[32:0]);
      c2   <= tcc_pkg::SqW'(scx[32:0]) + tcc_pkg::SqW'(scy[32:0]);
      // numerator products
      ax4  <= ax3; ay4 <= ay3;
      det4 <= det3;
      m1   <= $signed({1'b0, b2}) * cy3;
      m2   <= $signed({1'b0, c2}) * by3;
      m3   <= $signed({1'b0, c2}) * bx3;
      m4   <= $signed({1'b0, b2}) * cx3;
      // numerators
      ax5  <= ax4; ay5 <= ay4;
      det5 <= det4;
      nx   <= m1 - m2;
      ny   <= m3 - m4;
      // magnitudes and quotient signs
      x_side.coll <= (det5 == '0);
      x_side.neg  <= nx[tcc_pkg::NumerW-1] ^ det5[tcc_pkg::DetW-1];
      x_side.ax   <= ax5;
      x_side.ay   <= ay5;
      neg_y       <= ny[tcc_pkg::NumerW-1] ^ det5[tcc_pkg::DetW-1];
      num_x       <= {nx_mag, 8'b0};
      num_y       <= {ny_mag, 8'b0};
      den         <= det5[tcc_pkg::DetW-1] ? tcc_pkg::DenW'(-det5) : tcc_pkg::DenW'(det5);
    end
  end

  assign nx_mag = nx[tcc_pkg::NumerW-1] ? tcc_pkg::NumerW'(-nx) : tcc_pkg::NumerW'(nx);
  assign ny_mag = ny[tcc_pkg::NumerW-1] ? tcc_pkg::NumerW'(-ny) : tcc_pkg::NumerW'(ny);

  assign out_valid = vld[5];

endmodule
`default_nettype wire

@@ rtl/core/tcc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Depends on nothing outside this file.
`default_nettype none
module tcc_div #(
  parameter int NUM_W  = 60,
  parameter int DEN_W  = 36,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              ce,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_valid,
  output logic      [NUM_W-1:0]  quo,
  output logic                   rem_nz,
  output logic      [SIDE_W-1:0] side_out
);

  logic              vld [NUM_W];
  logic [DEN_W-1:0]  rem [NUM_W];
  logic [NUM_W-1:0]  nq  [NUM_W];   // numerator bits shift out, quotient bits shift in
  logic [DEN_W-1:0]  dn  [NUM_W];
  logic [SIDE_W-1:0] sd  [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              src_v;
    logic [DEN_W-1:0]  src_rem;
    logic [NUM_W-1:0]  src_nq;
    logic [DEN_W-1:0]  src_dn;
    logic [SIDE_W-1:0] src_sd;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign src_v   = in_valid;
      assign src_rem = '0;
      assign src_nq  = num;
      assign src_dn  = den;
      assign src_sd  = side_in;
    end else begin : g_next
      assign src_v   = vld[k-1];
      assign src_rem = rem[k-1];
      assign src_nq  = nq[k-1];
      assign src_dn  = dn[k-1];
      assign src_sd  = sd[k-1];
    end

    assign trial = {src_rem, src_nq[NUM_W-1]};
    assign diff  = trial - {1'b0, src_dn};
    assign ge    = (trial >= {1'b0, src_dn});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (ce) begin
        vld[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq[k]  <= {src_nq[NUM_W-2:0], ge};
        dn[k]  <= src_dn;
        sd[k]  <= src_sd;
      end
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign quo       = nq[NUM_W-1];
  assign rem_nz    = |rem[NUM_W-1];
  assign side_out  = sd[NUM_W-1];

endmodule
`default_nettype wire

@@ rtl/core/tcc_sqrt.sv @@
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on nothing outside this file.
`default_nettype none
module tcc_sqrt #(
  parameter int ROOT_W = 41,
  parameter int SIDE_W = 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                ce,
  input  wire logic                in_valid,
  input  wire logic [2*ROOT_W-1:0] rad,
  input  wire logic [SIDE_W-1:0]   side_in,
  output logic                     out_valid,
  output logic      [ROOT_W-1:0]   root,
  output logic      [SIDE_W-1:0]   side_out
);

  localparam int RadW = 2 * ROOT_W;
  localparam int RemW = ROOT_W + 2;
  localparam int CandW = RemW + 2;

  logic              vld [ROOT_W];
  logic [RemW-1:0]   rem [ROOT_W];
  logic [ROOT_W-1:0] rt  [ROOT_W];
  logic [RadW-1:0]   rs  [ROOT_W];
  logic [SIDE_W-1:0] sd  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              src_v;
    logic [RemW-1:0]   src_rem;
    logic [ROOT_W-1:0] src_rt;
    logic [RadW-1:0]   src_rs;
    logic [SIDE_W-1:0] src_sd;
    logic [CandW-1:0]  cand;
    logic [CandW-1:0]  trial;
    logic [CandW-1:0]  diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign src_v   = in_valid;
      assign src_rem = '0;
      assign src_rt  = '0;
      assign src_rs  = rad;
      assign src_sd  = side_in;
    end else begin : g_next
      assign src_v   = vld[k-1];
      assign src_rem = rem[k-1];
      assign src_rt  = rt[k-1];
      assign src_rs  = rs[k-1];
      assign src_sd  = sd[k-1];
    end

    assign cand  = {src_rem, src_rs[RadW-1 -: 2]};
    assign trial = CandW'({src_rt, 2'b01});
    assign diff  = cand - trial;
    assign ge    = (cand >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (ce) begin
        vld[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[k] <= ge ? diff[RemW-1:0] : cand[RemW-1:0];
        rt[k]  <= {src_rt[ROOT_W-2:0], ge};
        rs[k]  <= {src_rs[RadW-3:0], 2'b00};
        sd[k]  <= src_sd;
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign root      = rt[ROOT_W-1];
  assign side_out  = sd[ROOT_W-1];

endmodule
`default_nettype wire

@@ rtl/core/triangle_circumcircle_top.sv @@
// Top level of the triangle circumcircle block: stream ports, centre fixup, radius path.
// Depends on tcc_pkg, tcc_front, tcc_div and tcc_sqrt.
`default_nettype none
// Takes one triangle per clock and returns its circumcentre and circumradius in
// Q.8 with a status code (ok, collinear, saturated). The datapath is one pipeline
// of 116 register stages: 6 for the determinant and numerators, 60 for the two
// parallel one-bit-per-stage dividers, 8 for floor correction, clamping and the
// split squaring, and 41 for the one-bit-per-stage square root, plus the output
// register. Throughput is one item per cycle while results are taken. A
// two-entry output buffer sits in front of m_tdata, so s_tready stays high while
// at most one finished result waits; s_tready drops only when that buffer is
// full, and the whole pipeline then holds.
// Collinear vertices (including repeated ones) give zero centre and radius with
// status collinear. A centre outside the 40-bit signed range is clamped and the
// radius is taken from the clamped centre; either clamp sets status saturated.
module triangle_circumcircle_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // vertex_a_x[15:0], vertex_a_y[31:16], vertex_b_x[47:32],
  // vertex_b_y[63:48], vertex_c_x[79:64], vertex_c_y[95:80]
  input  wire logic [95:0]  s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // center_x[39:0], center_y[79:40], radius[119:80], status[121:120], zero[127:122]
  output logic      [127:0] m_tdata
);

  localparam int OutW = tcc_pkg::OutW;

  logic ce;

  // front end
  logic                          fr_valid;
  tcc_pkg::xside_t               fr_side;
  logic                          fr_neg_y;
  logic [tcc_pkg::NumW-1:0]      fr_num_x, fr_num_y;
  logic [tcc_pkg::DenW-1:0]      fr_den;

  // dividers
  logic                          dx_valid, dy_valid;
  logic [tcc_pkg::NumW-1:0]      qx, qy;
  logic                          rx_nz, ry_nz;
  tcc_pkg::xside_t               dx_side;
  logic                          dy_neg;

  // post-division pipeline
  logic [7:0]                    pv;
  tcc_pkg::xside_t               s1, s2;
  logic signed [tcc_pkg::CoordW-1:0] ax3, ay3;
  logic                          coll3, coll4, coll5, coll6, coll7, coll8;
  logic                          sat3, sat4, sat5, sat6, sat7, sat8;
  logic signed [61:0]            qfx, qfy, sumx, sumy;
  logic        [OutW-1:0]        px3, py3, px4, py4, px5, py5, px6, py6, px7, py7, px8, py8;
  logic signed [OutW:0]          ex4, ey4;
  logic        [OutW-1:0]        mx5, my5;
  logic        [63:0]            llx, lly;
  logic        [39:0]            lhx, lhy;
  logic        [15:0]            hhx, hhy;
  logic        [79:0]            sqx, sqy;
  logic        [tcc_pkg::RadW-1:0] rad8;
  logic        [tcc_pkg::NumW:0] magx, magy;
  logic                          ovx_pos, ovx_neg, ovy_pos, ovy_neg;

  // square root
  tcc_pkg::rside_t               sq_in_side, sq_side;
  logic                          sq_valid;
  logic [tcc_pkg::RootW-1:0]     root;

  // output buffer
  tcc_pkg::result_t              res_new;
  tcc_pkg::result_t              obuf [2];
  logic [1:0]                    cnt;
  logic                          wr_ptr, rd_ptr;
  logic                          push, pop;

  // the pipeline advances whenever the output buffer has room
  assign ce       = (cnt != 2'd2);
  assign s_tready = ce;

  tcc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (s_tvalid & ce),
    .a_x      (s_tdata[15:0]),
    .a_y      (s_tdata[31:16]),
    .b_x      (s_tdata[47:32]),
    .b_y      (s_tdata[63:48]),
    .c_x      (s_tdata[79:64]),
    .c_y      (s_tdata[95:80]),
    .out_valid(fr_valid),
    .x_side   (fr_side),
    .neg_y    (fr_neg_y),
    .num_x    (fr_num_x),
    .num_y    (fr_num_y),
    .den      (fr_den)
  );

  tcc_div #(
    .NUM_W (tcc_pkg::NumW),
    .DEN_W (tcc_pkg::DenW),
    .SIDE_W($bits(tcc_pkg::xside_t))
  ) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (fr_valid),
    .num      (fr_num_x),
    .den      (fr_den),
    .side_in  (fr_side),
    .out_valid(dx_valid),
    .quo      (qx),
    .rem_nz   (rx_nz),
    .side_out (dx_side)
  );

  tcc_div #(
    .NUM_W (tcc_pkg::NumW),
    .DEN_W (tcc_pkg::DenW),
    .SIDE_W(1)
  ) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (fr_valid),
    .num      (fr_num_y),
    .den      (fr_den),
    .side_in  (fr_neg_y),
    .out_valid(dy_valid),
    .quo      (qy),
    .rem_nz   (ry_nz),
    .side_out (dy_neg)
  );

  // floor adjustment: round the magnitude up when the quotient is negative and inexact
  assign magx = (tcc_pkg::NumW+1)'(qx) + (tcc_pkg::NumW+1)'(dx_side.neg & rx_nz);
  assign magy = (tcc_pkg::NumW+1)'(qy) + (tcc_pkg::NumW+1)'(dy_neg & ry_nz);

  // clamp detection: bits 61..39 must all agree for the value to fit 40 bits
  assign ovx_pos = ~sumx[61] & (|sumx[60:39]);
  assign ovx_neg =  sumx[61] & ~(&sumx[60:39]);
  assign ovy_pos = ~sumy[61] & (|sumy[60:39]);
  assign ovy_neg =  sumy[61] & ~(&sumy[60:39]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (ce) begin
      pv <= {pv[6:0], dx_valid & dy_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      // signed, floored offsets from vertex a
      s1  <= dx_side;
      qfx <= dx_side.neg ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
      qfy <= dy_neg      ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
      // absolute centre
      s2   <= s1;
      sumx <= qfx + (62'(s1.ax) <<< 8);
      sumy <= qfy + (62'(s1.ay) <<< 8);
      // clamp to 40 bits; carry vertex a along with the clamped centre
      coll3 <= s2.coll;
      ax3   <= s2.ax;
      ay3   <= s2.ay;
      sat3  <= ovx_pos | ovx_neg | ovy_pos | ovy_neg;
      px3   <= ovx_pos ? {1'b0, {(OutW-1){1'b1}}} : ovx_neg ? {1'b1, {(OutW-1){1'b0}}}
             : sumx[OutW-1:0];
      py3   <= ovy_pos ? {1'b0, {(OutW-1){1'b1}}} : ovy_neg ? {1'b1, {(OutW-1){1'b0}}}
             : sumy[OutW-1:0];
      // offsets from vertex a of the clamped centre
      coll4 <= coll3; sat4 <= sat3; px4 <= px3; py4 <= py3;
      ex4   <= $signed({px3[OutW-1], px3}) - ((OutW+1)'(ax3) <<< 8);
      ey4   <= $signed({py3[OutW-1], py3}) - ((OutW+1)'(ay3) <<< 8);
      // magnitudes
      coll5 <= coll4; sat5 <= sat4; px5 <= px4; py5 <= py4;
      mx5   <= ex4[OutW] ? OutW'(-ex4) : OutW'(ex4);
      my5   <= ey4[OutW] ? OutW'(-ey4) : OutW'(ey4);
      // partial products of the squares
      coll6 <= coll5; sat6 <= sat5; px6 <= px5; py6 <= py5;
      llx   <= mx5[31:0] * mx5[31:0];
      lhx   <= mx5[31:0] * mx5[39:32];
      hhx   <= mx5[39:32] * mx5[39:32];
      lly   <= my5[31:0] * my5[31:0];
      lhy   <= my5[31:0] * my5[39:32];
      hhy   <= my5[39:32] * my5[39:32];
      // squares
      coll7 <= coll6; sat7 <= sat6; px7 <= px6; py7 <= py6;
      sqx   <= (80'(hhx) << 64) + (80'(lhx) << 33) + 80'(llx);
      sqy   <= (80'(hhy) << 64) + (80'(lhy) << 33) + 80'(lly);
      // squared radius
      coll8 <= coll7; sat8 <= sat7; px8 <= px7; py8 <= py7;
      rad8  <= tcc_pkg::RadW'(sqx) + tcc_pkg::RadW'(sqy);
    end
  end

  assign sq_in_side.coll = coll8;
  assign sq_in_side.sat  = sat8;
  assign sq_in_side.px   = px8;
  assign sq_in_side.py   = py8;

  tcc_sqrt #(
    .ROOT_W(tcc_pkg::RootW),
    .SIDE_W($bits(tcc_pkg::rside_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (pv[7]),
    .rad      (rad8),
    .side_in  (sq_in_side),
    .out_valid(sq_valid),
    .root     (root),
    .side_out (sq_side)
  );

  // final result: radius clamp, collinear override
  always_comb begin
    if (sq_side.coll) begin
      res_new.center_x = '0;
      res_new.center_y = '0;
      res_new.radius   = '0;
      res_new.status   = tcc_pkg::ST_COLL;
    end else begin
      res_new.center_x = sq_side.px;
      res_new.center_y = sq_side.py;
      res_new.radius   = root[tcc_pkg::RootW-1] ? {OutW{1'b1}} : root[OutW-1:0];
      res_new.status   = (sq_side.sat | root[tcc_pkg::RootW-1]) ? tcc_pkg::ST_SAT
                                                                : tcc_pkg::ST_OK;
    end
  end

  // two-entry output buffer
  assign push = sq_valid & ce;
  assign pop  = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wr_ptr] <= res_new;
    end
  end

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = {6'b0, obuf[rd_ptr]};

endmodule
`default_nettype wire

@@ rtl/core/tcc_checker.sv @@
// Port-level checks for triangle_circumcircle_top, attached by the bind at the end.
// Depends on tcc_pkg and the top level's port names.
`default_nettype none
module tcc_props (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [127:0] m_tdata
);

  logic [1:0] st;
  assign st = m_tdata[121:120];

  // status code 3 means nothing
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (st == tcc_pkg::ST_OK || st == tcc_pkg::ST_COLL || st == tcc_pkg::ST_SAT))
    else $error("reserved status code on output");

  // a collinear triangle reports zero centre and radius
  a_coll_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && st == tcc_pkg::ST_COLL) |-> (m_tdata[119:0] == '0))
    else $error("collinear result with nonzero fields");

  // a full radius word only comes with the saturated status
  a_rad_sat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[119:80] == {40{1'b1}}) |-> (st == tcc_pkg::ST_SAT))
    else $error("maximum radius without saturated status");

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output item changed");

  // input backs up only while finished results wait
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result waiting");

endmodule

bind triangle_circumcircle_top tcc_props u_tcc_props (.*);
`default_nettype wire
